// ===== design/sit_pkg.sv =====
// Shared types, widths and constants for the segment intersection test pipeline.
// No dependencies; every other file imports this package.
`default_nettype none

package sit_pkg;

   // Coordinate width of every endpoint field.
   localparam int COORD_WIDTH = 32;

   // A coordinate difference needs one more bit than a coordinate.
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;

   // Operands are split into an unsigned low part and a signed high part so that
   // no single multiplier exceeds roughly 18 by 18 bits.
   localparam int SPLIT_WIDTH = (DIFF_WIDTH + 1) / 2;
   localparam int HIGH_WIDTH  = DIFF_WIDTH - SPLIT_WIDTH;

   // Partial product widths.
   localparam int PART_LL_WIDTH = 2 * SPLIT_WIDTH;
   localparam int PART_LH_WIDTH = SPLIT_WIDTH + 1 + HIGH_WIDTH;
   localparam int PART_HH_WIDTH = 2 * HIGH_WIDTH;

   // Exact product, and the exact sum or difference of two products.
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;

   // Pipeline stages.
   localparam int NUM_STAGES = 5;
   localparam int STG_DIFF   = 0;
   localparam int STG_PART   = 1;
   localparam int STG_PROD   = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_OUT    = 4;

   // Point-on-segment tests: which point is checked against which segment.
   localparam int NUM_TESTS = 4;
   localparam int TEST_A_B0 = 0;
   localparam int TEST_A_B1 = 1;
   localparam int TEST_B_A0 = 2;
   localparam int TEST_B_A1 = 3;

   // Products needed by one test (u and v are the two difference vectors).
   localparam int NUM_PRODS = 4;
   localparam int PROD_UXVY = 0;
   localparam int PROD_UYVX = 1;
   localparam int PROD_UXVX = 2;
   localparam int PROD_UYVY = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type a0;
      point_type a1;
      point_type b0;
      point_type b1;
   } quad_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
   } vec_type;

   // Per-stage load enables from the pipeline control.
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// ===== design/sit_ifs.sv =====
// Valid/ready channel interfaces for the segment pairs and the result bits.
// Depends on sit_pkg for the coordinate type.
`default_nettype none

interface sit_req_if import sit_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type a0_x;
   coord_type a0_y;
   coord_type a1_x;
   coord_type a1_y;
   coord_type b0_x;
   coord_type b0_y;
   coord_type b1_x;
   coord_type b1_y;

   modport source (
      output valid, a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y,
      input  ready
   );
   modport sink (
      input  valid, a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y,
      output ready
   );
endinterface

interface sit_rsp_if ();
   logic valid;
   logic ready;
   logic intersects;

   modport source (output valid, intersects, input ready);
   modport sink (input valid, intersects, output ready);
endinterface

`default_nettype wire

// ===== design/sit_ctrl.sv =====
// Valid bits and per-stage load enables of the intersection pipeline.
// Depends on sit_pkg for the stage count and the control struct.
`default_nettype none

module sit_ctrl import sit_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   output logic        out_valid,
   input  wire logic   out_ready,
   output pipe_ctl_type ctl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;
   logic [NUM_STAGES-1:0] up_valid;

   // A stage loads when it is empty or its word moves on this cycle.
   assign ready[NUM_STAGES] = out_ready;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   assign up_valid = {valid_ff[NUM_STAGES-2:0], in_valid};
   assign valid_in = (ready[NUM_STAGES-1:0] & up_valid) | (~ready[NUM_STAGES-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = ready[NUM_STAGES-1:0];
   assign in_ready  = ready[STG_DIFF];
   assign out_valid = valid_ff[STG_OUT];

endmodule

`default_nettype wire

// ===== design/sit_diff.sv =====
// First stage: the difference vectors of the four point-on-segment tests.
// Depends on sit_pkg for the point, vector and test index definitions.
`default_nettype none

module sit_diff import sit_pkg::*; (
   input  wire logic         clock,
   input  wire pipe_ctl_type ctl,
   input  wire quad_type     pts,
   output vec_type           u_ff [NUM_TESTS],
   output vec_type           v_ff [NUM_TESTS]
);

   vec_type u_in [NUM_TESTS];
   vec_type v_in [NUM_TESTS];

   function automatic vec_type vec_sub(point_type p, point_type q);
      vec_type r;
      r.x = diff_type'(p.x) - diff_type'(q.x);
      r.y = diff_type'(p.y) - diff_type'(q.y);
      return r;
   endfunction

   // For point q against segment p0-p1: u = p0 - q, v = p1 - q.
   always_comb begin
      u_in[TEST_A_B0] = vec_sub(pts.a0, pts.b0);
      v_in[TEST_A_B0] = vec_sub(pts.a1, pts.b0);
      u_in[TEST_A_B1] = vec_sub(pts.a0, pts.b1);
      v_in[TEST_A_B1] = vec_sub(pts.a1, pts.b1);
      u_in[TEST_B_A0] = vec_sub(pts.b0, pts.a0);
      v_in[TEST_B_A0] = vec_sub(pts.b1, pts.a0);
      u_in[TEST_B_A1] = vec_sub(pts.b0, pts.a1);
      v_in[TEST_B_A1] = vec_sub(pts.b1, pts.a1);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_DIFF]) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sit_mul.sv =====
// Two-stage exact signed multiplier built from four narrow partial products.
// Depends on sit_pkg for the operand split and the product width.
`default_nettype none

module sit_mul import sit_pkg::*; (
   input  wire logic         clock,
   input  wire pipe_ctl_type ctl,
   input  wire diff_type     op_a,
   input  wire diff_type     op_b,
   output prod_type          prod_ff
);

   logic        [SPLIT_WIDTH-1:0]   a_lo;
   logic        [SPLIT_WIDTH-1:0]   b_lo;
   logic signed [HIGH_WIDTH-1:0]    a_hi;
   logic signed [HIGH_WIDTH-1:0]    b_hi;

   logic        [PART_LL_WIDTH-1:0] ll_in, ll_ff;
   logic signed [PART_LH_WIDTH-1:0] lh_in, lh_ff;
   logic signed [PART_LH_WIDTH-1:0] hl_in, hl_ff;
   logic signed [PART_HH_WIDTH-1:0] hh_in, hh_ff;
   prod_type                        prod_in;

   assign a_lo = op_a[SPLIT_WIDTH-1:0];
   assign b_lo = op_b[SPLIT_WIDTH-1:0];
   assign a_hi = op_a[DIFF_WIDTH-1:SPLIT_WIDTH];
   assign b_hi = op_b[DIFF_WIDTH-1:SPLIT_WIDTH];

   // The low halves are unsigned, so they enter the mixed products with a zero on top.
   assign ll_in = PART_LL_WIDTH'(a_lo) * PART_LL_WIDTH'(b_lo);
   assign lh_in = PART_LH_WIDTH'($signed({1'b0, a_lo})) * PART_LH_WIDTH'(b_hi);
   assign hl_in = PART_LH_WIDTH'(a_hi) * PART_LH_WIDTH'($signed({1'b0, b_lo}));
   assign hh_in = PART_HH_WIDTH'(a_hi) * PART_HH_WIDTH'(b_hi);

   always_ff @(posedge clock) begin
      if (ctl.load[STG_PART]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   // The true product fits in PROD_WIDTH bits, so wrapping in the sum is harmless.
   assign prod_in = (prod_type'(hh_ff) <<< (2 * SPLIT_WIDTH))
                  + ((prod_type'(lh_ff) + prod_type'(hl_ff)) <<< SPLIT_WIDTH)
                  + prod_type'(ll_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[STG_PROD]) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sit_eval.sv =====
// Last two stages: cross and dot products, then the touch-or-cross decision.
// Depends on sit_pkg for the test and product indexes and the sum width.
`default_nettype none

module sit_eval import sit_pkg::*; (
   input  wire logic         clock,
   input  wire pipe_ctl_type ctl,
   input  wire prod_type     prod [NUM_TESTS][NUM_PRODS],
   output logic              hit_ff
);

   sum_type cross_in [NUM_TESTS];
   sum_type cross_ff [NUM_TESTS];
   sum_type dot_in   [NUM_TESTS];
   sum_type dot_ff   [NUM_TESTS];

   logic [NUM_TESTS-1:0] cross_zero;
   logic [NUM_TESTS-1:0] cross_neg;
   logic [NUM_TESTS-1:0] on_seg;
   logic                 straddle_a;
   logic                 straddle_b;
   logic                 hit_in;

   for (genvar t = 0; t < NUM_TESTS; t++) begin : g_test
      assign cross_in[t] = sum_type'(prod[t][PROD_UXVY]) - sum_type'(prod[t][PROD_UYVX]);
      assign dot_in[t]   = sum_type'(prod[t][PROD_UXVX]) + sum_type'(prod[t][PROD_UYVY]);

      assign cross_zero[t] = (cross_ff[t] == '0);
      assign cross_neg[t]  = cross_ff[t][SUM_WIDTH-1];
      assign on_seg[t]     = cross_zero[t] && (dot_ff[t][SUM_WIDTH-1] || (dot_ff[t] == '0));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_SUM]) begin
         cross_ff <= cross_in;
         dot_ff   <= dot_in;
      end
   end

   // The straddle orientations are the negated on-segment cross products; a common
   // sign flip does not change whether the two signs are opposite.
   assign straddle_a = !cross_zero[TEST_A_B0] && !cross_zero[TEST_A_B1]
                     && (cross_neg[TEST_A_B0] != cross_neg[TEST_A_B1]);
   assign straddle_b = !cross_zero[TEST_B_A0] && !cross_zero[TEST_B_A1]
                     && (cross_neg[TEST_B_A0] != cross_neg[TEST_B_A1]);

   assign hit_in = (|on_seg) || (straddle_a && straddle_b);

   always_ff @(posedge clock) begin
      if (ctl.load[STG_OUT]) begin
         hit_ff <= hit_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/segment_intersection_test_top.sv =====
// Top level of the segment intersection test: a five-stage pipeline.
// Depends on sit_pkg, sit_ifs, sit_ctrl, sit_diff, sit_mul and sit_eval.
//
//   Channel   Direction  Carries
//   req_bus   in         a0_x a0_y a1_x a1_y b0_x b0_y b1_x b1_y (signed coordinates)
//   rsp_bus   out        intersects (1 bit, one word per request word)
//
// Throughput is one word per cycle while the result is taken; an accepted word
// passes one pipeline register per stage before its result is offered: differences,
// partial products, products, cross and dot sums, and the decision bit.
// Reset clears only the stage valid bits; the data registers need no reset.
// When the result is not taken, words close up behind it and stages still empty keep
// loading; ready then drops stage by stage, so no word is lost or repeated.
`default_nettype none

module segment_intersection_test_top import sit_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   sit_req_if.sink   req_bus,
   sit_rsp_if.source rsp_bus
);

   pipe_ctl_type ctl;
   quad_type     pts;
   vec_type      u_vec [NUM_TESTS];
   vec_type      v_vec [NUM_TESTS];
   prod_type     prod  [NUM_TESTS][NUM_PRODS];
   logic         hit;

   // The control block owns every valid bit; the data path only follows its load enables.
   sit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   // Gather the request word into one endpoint bundle.
   assign pts.a0.x = req_bus.a0_x;
   assign pts.a0.y = req_bus.a0_y;
   assign pts.a1.x = req_bus.a1_x;
   assign pts.a1.y = req_bus.a1_y;
   assign pts.b0.x = req_bus.b0_x;
   assign pts.b0.y = req_bus.b0_y;
   assign pts.b1.x = req_bus.b1_x;
   assign pts.b1.y = req_bus.b1_y;

   // Stage one: the eight difference vectors for the four endpoint tests.
   sit_diff u_diff (
      .clock (clock),
      .ctl   (ctl),
      .pts   (pts),
      .u_ff  (u_vec),
      .v_ff  (v_vec)
   );

   // Stages two and three: sixteen exact products, four per test. Two of the four
   // products form the cross product of a test and the other two its dot product.
   for (genvar t = 0; t < NUM_TESTS; t++) begin : g_mul
      sit_mul u_mul_uxvy (
         .clock   (clock),
         .ctl     (ctl),
         .op_a    (u_vec[t].x),
         .op_b    (v_vec[t].y),
         .prod_ff (prod[t][PROD_UXVY])
      );
      sit_mul u_mul_uyvx (
         .clock   (clock),
         .ctl     (ctl),
         .op_a    (u_vec[t].y),
         .op_b    (v_vec[t].x),
         .prod_ff (prod[t][PROD_UYVX])
      );
      sit_mul u_mul_uxvx (
         .clock   (clock),
         .ctl     (ctl),
         .op_a    (u_vec[t].x),
         .op_b    (v_vec[t].x),
         .prod_ff (prod[t][PROD_UXVX])
      );
      sit_mul u_mul_uyvy (
         .clock   (clock),
         .ctl     (ctl),
         .op_a    (u_vec[t].y),
         .op_b    (v_vec[t].y),
         .prod_ff (prod[t][PROD_UYVY])
      );
   end

   // Stages four and five: sums, signs and the final decision. The straddle test
   // reuses the cross products of the endpoint tests, so no extra multipliers exist.
   sit_eval u_eval (
      .clock  (clock),
      .ctl    (ctl),
      .prod   (prod),
      .hit_ff (hit)
   );

   assign rsp_bus.intersects = hit;

endmodule

`default_nettype wire

// ===== dv/tb_segment_intersection_test_top.sv =====
// Self-checking testbench for segment_intersection_test_top: drives segment pairs,
// predicts the intersects bit from exact signed arithmetic and checks every result word.
// Depends on sit_pkg, sit_ifs and the design files under design/.
`default_nettype none

module tb_segment_intersection_test_top;
   import sit_pkg::*;

   // Bound on the watchdog's cycle counter; a run still going when it is reached fails.
   localparam int CYCLE_LIMIT = 200000;

   // Extreme coordinate values of a COORD_WIDTH two's complement field.
   localparam coord_type CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   // Wide enough to hold every difference, product and sum exactly.
   typedef logic signed [2*DIFF_WIDTH+5:0] exact_type;

   // Keeps the expected intersects bits of accepted pairs, oldest first, and compares
   // each result word against the head of that queue.
   class hit_ledger;
      bit pending_hits[$];
      int failures = 0;

      function int sign_of(input exact_type v);
         if (v == 0) return 0;
         return (v < 0) ? -1 : 1;
      endfunction

      function exact_type cross_of(input exact_type ux, input exact_type uy,
                                   input exact_type vx, input exact_type vy);
         return ux * vy - uy * vx;
      endfunction

      // Point q is on the closed segment p0-p1 when (p0-q) and (p1-q) are parallel
      // and do not point the same way.
      function bit lies_on(input exact_type p0x, input exact_type p0y,
                           input exact_type p1x, input exact_type p1y,
                           input exact_type qx, input exact_type qy);
         exact_type ux, uy, vx, vy;
         ux = p0x - qx;
         uy = p0y - qy;
         vx = p1x - qx;
         vy = p1y - qy;
         return sign_of(cross_of(ux, uy, vx, vy)) == 0 && sign_of(ux * vx + uy * vy) <= 0;
      endfunction

      // True when q0 and q1 lie strictly on opposite sides of the line through p0-p1.
      function bit straddles(input exact_type p0x, input exact_type p0y,
                             input exact_type p1x, input exact_type p1y,
                             input exact_type q0x, input exact_type q0y,
                             input exact_type q1x, input exact_type q1y);
         int s0, s1;
         s0 = sign_of(cross_of(p1x - q0x, p1y - q0y, p0x - q0x, p0y - q0y));
         s1 = sign_of(cross_of(p1x - q1x, p1y - q1y, p0x - q1x, p0y - q1y));
         return s0 * s1 == -1;
      endfunction

      function bit segments_meet(input quad_type q);
         exact_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
         ax0 = q.a0.x; ay0 = q.a0.y; ax1 = q.a1.x; ay1 = q.a1.y;
         bx0 = q.b0.x; by0 = q.b0.y; bx1 = q.b1.x; by1 = q.b1.y;
         if (lies_on(ax0, ay0, ax1, ay1, bx0, by0) || lies_on(ax0, ay0, ax1, ay1, bx1, by1) ||
             lies_on(bx0, by0, bx1, by1, ax0, ay0) || lies_on(bx0, by0, bx1, by1, ax1, ay1))
            return 1'b1;
         return straddles(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1) &&
                straddles(bx0, by0, bx1, by1, ax0, ay0, ax1, ay1);
      endfunction

      function void note_pair(input quad_type q);
         pending_hits.push_back(segments_meet(q));
      endfunction

      function void check_hit(input bit actual);
         bit expected;
         if (pending_hits.size() == 0) begin
            $error("intersects: no word expected, actual %0b", actual);
            failures++;
            return;
         end
         expected = pending_hits.pop_front();
         if (actual !== expected) begin
            $error("intersects: expected %0b, actual %0b", expected, actual);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sit_req_if req_bus ();
   sit_rsp_if rsp_bus ();

   segment_intersection_test_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hit_ledger board = new();

   // Idle and stall rates in percent for the current phase; hold_left, when set, makes
   // the receiver refuse words until it has counted down to zero, no matter what stall_pct says.
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic quad_type pair_of(input coord_type ax0, input coord_type ay0,
                                        input coord_type ax1, input coord_type ay1,
                                        input coord_type bx0, input coord_type by0,
                                        input coord_type bx1, input coord_type by1);
      quad_type q;
      q.a0.x = ax0; q.a0.y = ay0; q.a1.x = ax1; q.a1.y = ay1;
      q.b0.x = bx0; q.b0.y = by0; q.b1.x = bx1; q.b1.y = by1;
      return q;
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(6))
         0: return CMIN;
         1: return CMAX;
         2: return 0;
         3: return 1;
         4: return -1;
         5: return CMIN + 1;
         default: return CMAX - 1;
      endcase
   endfunction

   function automatic coord_type box_coord();
      return coord_type'(int'($urandom_range(16)) - 8);
   endfunction

   // Four points on one line: base + t * d.  Most land on or near each other, so the
   // collinear overlap, touch and gap cases all come up; some segments collapse to
   // points, and some get a one-unit nudge off the line.
   function automatic quad_type collinear_pair();
      int bx, by, dx, dy, scale;
      int t[4];
      quad_type q;
      int pick;
      bx = int'($urandom) >>> 2;
      by = int'($urandom) >>> 2;
      scale = $urandom_range(1) ? 1 : (1 << 23);
      dx = (int'($urandom_range(16)) - 8) * scale;
      dy = (int'($urandom_range(16)) - 8) * scale;
      foreach (t[i]) t[i] = int'($urandom_range(16)) - 8;
      q = pair_of(bx + t[0] * dx, by + t[0] * dy, bx + t[1] * dx, by + t[1] * dy,
                  bx + t[2] * dx, by + t[2] * dy, bx + t[3] * dx, by + t[3] * dy);
      pick = $urandom_range(9);
      if (pick < 2) begin
         q.a1 = q.a0;
      end else if (pick < 4) begin
         q.b1 = q.b0;
      end else if (pick == 4) begin
         q.a1 = q.a0;
         q.b1 = q.b0;
      end
      if ($urandom_range(3) == 0) q.b0.y = q.b0.y + 1;
      return q;
   endfunction

   // Segment B starts at the midpoint of A or at A's second endpoint, or ends at A's first,
   // with full-range coordinates; an odd span makes the midpoint miss by half a unit.
   function automatic quad_type touching_pair();
      quad_type q;
      q = pair_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      case ($urandom_range(2))
         0: begin
            q.b0.x = coord_type'((longint'(q.a0.x) + longint'(q.a1.x)) >>> 1);
            q.b0.y = coord_type'((longint'(q.a0.y) + longint'(q.a1.y)) >>> 1);
         end
         1: q.b0 = q.a1;
         default: q.b1 = q.a0;
      endcase
      return q;
   endfunction

   function automatic quad_type random_pair();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15)
         return pair_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
      if (pick < 40)
         return pair_of(box_coord(), box_coord(), box_coord(), box_coord(),
                        box_coord(), box_coord(), box_coord(), box_coord());
      if (pick < 70)
         return collinear_pair();
      if (pick < 85)
         return touching_pair();
      return pair_of(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                     extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
   endfunction

   // Offers one word and returns at the edge that accepts it.  Valid stays high between
   // back-to-back words and only drops when the sender decides to idle.
   task automatic send_pair(input quad_type q);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.a0_x  <= q.a0.x;
      req_bus.a0_y  <= q.a0.y;
      req_bus.a1_x  <= q.a1.x;
      req_bus.a1_y  <= q.a1.y;
      req_bus.b0_x  <= q.b0.x;
      req_bus.b0_y  <= q.b0.y;
      req_bus.b1_x  <= q.b1.x;
      req_bus.b1_y  <= q.b1.y;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      board.note_pair(q);
   endtask

   // The sender goes quiet until every expected result word has been taken.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.pending_hits.size() != 0);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count, input int hold);
      idle_pct  = idle;
      stall_pct = stall;
      hold_left = hold;
      repeat (count) send_pair(random_pair());
      drain();
   endtask

   // Receiver: checks each word taken at an edge, then picks ready for the next cycle.
   // A pending hold-off is counted down here at each edge.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) board.check_hit(rsp_bus.intersects);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog: a run that has not finished when cycle_count reaches CYCLE_LIMIT has hung and fails.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("segment_intersection_test_top regression: fail");
      $finish;
   end

   initial begin
      quad_type directed[$];

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.a0_x  <= '0;
      req_bus.a0_y  <= '0;
      req_bus.a1_x  <= '0;
      req_bus.a1_y  <= '0;
      req_bus.b0_x  <= '0;
      req_bus.b0_y  <= '0;
      req_bus.b1_x  <= '0;
      req_bus.b1_y  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every endpoint at the most negative and at the most positive value: all four
      // points coincide, so these are point segments that meet.
      directed.push_back(pair_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
      directed.push_back(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
      // Full-range diagonals that cross properly; the products need all their bits.
      directed.push_back(pair_of(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
      // The origin as a point segment: on the full diagonal, then one unit off it.
      directed.push_back(pair_of(CMIN, CMIN, CMAX, CMAX, 0, 0, 0, 0));
      directed.push_back(pair_of(CMIN, CMIN, CMAX, CMAX, 0, 1, 0, 1));
      // Parallel full-width segments at the bottom and top edges.
      directed.push_back(pair_of(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX));
      // Collinear: overlapping, separated by a gap, and touching end to end.
      directed.push_back(pair_of(0, 0, 10, 0, 5, 0, 20, 0));
      directed.push_back(pair_of(0, 0, 4, 4, 5, 5, 9, 9));
      directed.push_back(pair_of(0, 0, 4, 4, 4, 4, 9, 9));
      // An endpoint on the interior of the other segment, a near miss above it, and a crossing.
      directed.push_back(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
      directed.push_back(pair_of(0, 0, 10, 0, 5, 1, 5, 7));
      directed.push_back(pair_of(0, 0, 4, 4, 0, 4, 4, 0));
      // Two point segments, equal and then distinct.
      directed.push_back(pair_of(3, -2, 3, -2, 3, -2, 3, -2));
      directed.push_back(pair_of(1, 1, 1, 1, 2, 2, 2, 2));
      // A point segment on B, and one on B's line but past its end.
      directed.push_back(pair_of(2, 3, 2, 3, 0, 0, 4, 6));
      directed.push_back(pair_of(6, 9, 6, 9, 0, 0, 4, 6));
      // The lines cross, but the crossing lies past the end of A.
      directed.push_back(pair_of(0, 0, 1, 1, 3, 0, 0, 3));
      // Near the top corner: just off the full diagonal, then just on it.
      directed.push_back(pair_of(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX - 1, CMAX, CMAX - 1));
      directed.push_back(pair_of(CMIN, CMIN, CMAX, CMAX, CMAX - 1, CMAX - 1, CMAX - 1,
                                 CMAX - 1));
      // Full-length axes crossing at the origin.
      directed.push_back(pair_of(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
      // Reversed diagonal with B starting on it at (-1, -1).
      directed.push_back(pair_of(CMAX, CMAX, CMIN, CMIN, -1, -1, -1, CMAX));
      // A short segment lying inside a full-width one.
      directed.push_back(pair_of(CMIN, 0, CMAX, 0, -5, 0, 5, 0));
      // A corner point segment against the edge that starts there.
      directed.push_back(pair_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN));

      foreach (directed[i]) send_pair(directed[i]);
      drain();

      // No idling at first, with a long hold-off at the receiver so the pipeline fills
      // and req ready drops while words are still being offered.
      run_phase(0, 0, 150, 80);
      // Sender idle most of the time.
      run_phase(83, 0, 130, 0);
      // Receiver stalling most of the time.
      run_phase(0, 83, 130, 0);
      // Light idling on both sides.
      run_phase(6, 6, 140, 0);

      // Let any stray word leave the pipeline before the verdict.
      repeat (4 * NUM_STAGES) @(posedge clock);
      if (board.pending_hits.size() != 0) begin
         $error("intersects: %0d words never arrived", board.pending_hits.size());
         board.failures++;
      end
      if (board.failures == 0)
         $display("segment_intersection_test_top regression: pass");
      else
         $display("segment_intersection_test_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/sit_pkg.sv
design/sit_ifs.sv
design/sit_ctrl.sv
design/sit_diff.sv
design/sit_mul.sv
design/sit_eval.sv
design/segment_intersection_test_top.sv
dv/tb_segment_intersection_test_top.sv
